// ----- hdl/mpnb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpnb_pkg
// Shared types and constants for the MIDI parser with note bitmap.
// ----------------------------------------------------------------------------
package mpnb_pkg;

	localparam int BITMAP_WORDS = 8;
	localparam int BM_IDX_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam logic [3:0] BM_WORDS_L = 4'(BITMAP_WORDS);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam logic [QCNT_W-1:0] QDEPTH_L = QCNT_W'(QDEPTH);

	localparam int PADDR_W = 4;

	localparam logic [1:0] REG_CHAIN_CHANNEL = 2'd0;
	localparam logic [1:0] REG_CHAIN_BASE    = 2'd1;
	localparam logic [1:0] REG_CHAIN_MAX     = 2'd2;

	localparam logic [7:0] ST_REALTIME = 8'hF8;
	localparam logic [7:0] ST_SYSCOM   = 8'hF0;
	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
	localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
	localparam logic [3:0] CMD_CTRL     = 4'hB;
	localparam logic [3:0] CMD_PROG     = 4'hC;
	localparam logic [3:0] CMD_PRES     = 4'hD;

	typedef enum logic [1:0] {
		KIND_NOTE_ON  = 2'd0,
		KIND_NOTE_OFF = 2'd1,
		KIND_CTRL     = 2'd2,
		KIND_WORD     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] ch;
		logic [6:0] d1;
		logic [6:0] d2;
	} req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [3:0] chain_channel;
		logic [6:0] chain_base_note;
		logic [6:0] chain_max_note;
	} cfg_t;

endpackage
`default_nettype wire

// ----- hdl/midi_parser_note_bitmap.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// midi_parser_note_bitmap
// MIDI running-status parser driving a chain note bitmap.
// ----------------------------------------------------------------------------
// channel   handshake               payload
// config    psel/penable/pready     paddr, pwdata, prdata
// input     in_valid/in_ready       rx_byte
// output    out_valid/out_ready     kind, channel, data_one, data_two,
//                                   word_index, word_value
//
// One byte per cycle while in_ready is high; a completed note or controller
// message goes through the request queue, then the output register.
// in_ready drops only while the two-entry request queue is full.
// A stalled output holds the queue; the parser keeps taking bytes until
// the queue fills. Reset clears parser state, queue, bitmap and registers.
// ----------------------------------------------------------------------------
module midi_parser_note_bitmap (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mpnb_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         kind,
	output logic [4:0]                         channel,
	output logic [6:0]                         data_one,
	output logic [6:0]                         data_two,
	output logic [2:0]                         word_index,
	output logic [15:0]                        word_value
);
	import mpnb_pkg::*;

	cfg_t   cfg_q;
	logic   wr_en;
	logic [1:0] reg_idx;
	logic   accept;
	logic   push;
	req_t   push_req;
	logic   pop;
	req_t   head;
	qstat_t qstat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chain_channel   <= 4'd0;
			cfg_q.chain_base_note <= 7'd0;
			cfg_q.chain_max_note  <= 7'd127;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CHAIN_CHANNEL: cfg_q.chain_channel   <= pwdata[3:0];
				REG_CHAIN_BASE:    cfg_q.chain_base_note <= pwdata[6:0];
				REG_CHAIN_MAX:     cfg_q.chain_max_note  <= pwdata[6:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CHAIN_CHANNEL: prdata = {28'd0, cfg_q.chain_channel};
			REG_CHAIN_BASE:    prdata = {25'd0, cfg_q.chain_base_note};
			REG_CHAIN_MAX:     prdata = {25'd0, cfg_q.chain_max_note};
			default:           prdata = 32'd0;
		endcase
	end

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	mpnb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.push     (push),
		.push_req (push_req)
	);

	mpnb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	mpnb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.kind       (kind),
		.channel    (channel),
		.data_one   (data_one),
		.data_two   (data_two),
		.word_index (word_index),
		.word_value (word_value)
	);

`ifndef SYNTH
	a_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_WORD |->
			channel == 5'd0 && data_one == 7'd0 && data_two == 7'd0)
		else $error("bitmap word result carries message fields");

	a_msg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_WORD |->
			channel != 5'd0 && word_index == 3'd0 && word_value == 16'd0)
		else $error("forwarded message carries bitmap fields");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> !pop)
		else $error("request popped from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("request pushed into full queue");
`endif

endmodule
`default_nettype wire

// ----- hdl/mpnb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpnb_front
// Running-status byte parser; issues complete note and controller requests.
// ----------------------------------------------------------------------------
module mpnb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    rx_byte,
	output logic               push,
	output mpnb_pkg::req_t     push_req
);
	import mpnb_pkg::*;

	logic [7:0] running_status_q;
	logic [6:0] first_data_q;
	logic [1:0] data_count_q;
	logic [1:0] data_needed_q;

	logic [1:0] count_next;
	logic       complete;
	logic [3:0] cmd;

	assign count_next = data_count_q + 2'd1;
	assign complete   = !rx_byte[7] && (running_status_q != 8'd0) &&
		(count_next >= data_needed_q);
	assign cmd        = running_status_q[7:4];

	always_comb begin
		push_req.ch = running_status_q[3:0];
		push_req.d1 = (data_count_q == 2'd0) ? rx_byte[6:0] : first_data_q;
		push_req.d2 = rx_byte[6:0];
		push_req.kind = KIND_CTRL;
		push = 1'b0;
		if (accept && complete) begin
			if (cmd == CMD_NOTE_ON && rx_byte[6:0] != 7'd0) begin
				push_req.kind = KIND_NOTE_ON;
				push = 1'b1;
			end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
				push_req.kind = KIND_NOTE_OFF;
				push = 1'b1;
			end else if (cmd == CMD_CTRL) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_status_q <= 8'd0;
			first_data_q     <= 7'd0;
			data_count_q     <= 2'd0;
			data_needed_q    <= 2'd0;
		end else if (accept) begin
			if (rx_byte[7]) begin
				if (rx_byte >= ST_REALTIME) begin
					running_status_q <= running_status_q;
				end else if (rx_byte >= ST_SYSCOM) begin
					running_status_q <= 8'd0;
					data_count_q     <= 2'd0;
				end else begin
					running_status_q <= rx_byte;
					data_count_q     <= 2'd0;
					data_needed_q    <= (rx_byte[7:4] == CMD_PROG ||
						rx_byte[7:4] == CMD_PRES) ? 2'd1 : 2'd2;
				end
			end else if (running_status_q != 8'd0) begin
				if (data_count_q == 2'd0)
					first_data_q <= rx_byte[6:0];
				data_count_q <= complete ? 2'd0 : count_next;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mpnb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpnb_queue
// Short request queue between the parser and the bitmap/forward unit.
// ----------------------------------------------------------------------------
module mpnb_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mpnb_pkg::req_t push_req,
	input  wire logic          pop,
	output mpnb_pkg::req_t     head,
	output mpnb_pkg::qstat_t   stat
);
	import mpnb_pkg::*;

	req_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == QDEPTH_L);
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mpnb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpnb_back
// Chain note bitmap update and message forwarding into the output register.
// ----------------------------------------------------------------------------
module mpnb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mpnb_pkg::cfg_t cfg,
	input  wire mpnb_pkg::req_t head,
	input  wire mpnb_pkg::qstat_t qstat,
	output logic                pop,
	input  wire logic           out_ready,
	output logic                out_valid,
	output logic [1:0]          kind,
	output logic [4:0]          channel,
	output logic [6:0]          data_one,
	output logic [6:0]          data_two,
	output logic [2:0]          word_index,
	output logic [15:0]         word_value
);
	import mpnb_pkg::*;

	logic [15:0] bitmap_q [BITMAP_WORDS];
	logic        valid_q;
	kind_t       kind_q;
	logic [4:0]  channel_q;
	logic [6:0]  d1_q;
	logic [6:0]  d2_q;
	logic [2:0]  widx_q;
	logic [15:0] wval_q;

	logic              is_note;
	logic              is_chain;
	logic              in_window;
	logic [6:0]        idx;
	logic [2:0]        w;
	logic [BM_IDX_W-1:0] w_sel;
	logic              in_cap;
	logic [15:0]       new_word;
	logic              produce;

	assign pop       = !qstat.empty && (!valid_q || out_ready);
	assign is_note   = (head.kind == KIND_NOTE_ON) || (head.kind == KIND_NOTE_OFF);
	assign is_chain  = is_note && (head.ch == cfg.chain_channel);
	assign in_window = (head.d1 >= cfg.chain_base_note) &&
		(head.d1 <= cfg.chain_max_note);
	assign idx       = head.d1 - cfg.chain_base_note;
	assign w         = idx[6:4];
	assign w_sel     = w[BM_IDX_W-1:0];
	assign in_cap    = ({1'b0, w} < BM_WORDS_L);
	assign new_word  = (head.kind == KIND_NOTE_ON) ?
		(bitmap_q[w_sel] | (16'd1 << idx[3:0])) :
		(bitmap_q[w_sel] & ~(16'd1 << idx[3:0]));
	assign produce   = !is_chain || (in_window && in_cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BITMAP_WORDS; i++)
				bitmap_q[i] <= 16'd0;
		end else if (pop && is_chain && in_window && in_cap) begin
			bitmap_q[w_sel] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= produce;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (is_chain) begin
				kind_q    <= KIND_WORD;
				channel_q <= 5'd0;
				d1_q      <= 7'd0;
				d2_q      <= 7'd0;
				widx_q    <= w;
				wval_q    <= new_word;
			end else begin
				kind_q    <= head.kind;
				channel_q <= {1'b0, head.ch} + 5'd1;
				d1_q      <= head.d1;
				d2_q      <= head.d2;
				widx_q    <= 3'd0;
				wval_q    <= 16'd0;
			end
		end
	end

	assign out_valid  = valid_q;
	assign kind       = kind_q;
	assign channel    = channel_q;
	assign data_one   = d1_q;
	assign data_two   = d2_q;
	assign word_index = widx_q;
	assign word_value = wval_q;

endmodule
`default_nettype wire
